// File: src/gbts_pkg.sv
// Shared types and codes for the gap buffer text store.
package gbts_pkg;

	// Request kinds carried on the input side-band
	typedef enum logic [2:0] {
		REQ_INSERT     = 3'd0,
		REQ_DEL_LEFT   = 3'd1,
		REQ_DEL_RIGHT  = 3'd2,
		REQ_MOVE_LEFT  = 3'd3,
		REQ_MOVE_RIGHT = 3'd4,
		REQ_READ       = 3'd5
	} req_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_RANGE  = 2'd2,
		STAT_BEYOND = 2'd3
	} status_t;

	// Control sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COPY,
		ST_FINISH
	} state_t;

endpackage

// File: src/gbts_ram.sv
// Generic simple dual-port RAM with registered read data.
module gbts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, read one entry into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/gap_buffer_text_store.sv
// Gap buffer text store: one request in, one result out, text held in a RAM.
//
// Input channel s_*: one request per transfer; s_tuser holds the request kind
// (insert, delete left/right, move left/right, read) and s_tdata its operands.
// Output channel m_*: exactly one result per request, in request order, with
// status, the character read, the text length and the cursor (gap start).
// Insert, delete, read and ignored requests go from acceptance through the
// finish step into the result register; a gap move of n cells passes through
// the copy step before the finish step, since the copy moves one byte per
// cycle through the single read port of the RAM and writes it back in the
// cycle after through the write port.
// A new request is accepted once the previous one has finished its work; a
// finished result waits in the output register while the next request runs.
// If the receiver stalls, the following result is held until the output
// register frees and no further request is taken meanwhile.
// Reset empties the text: cursor 0 and the gap spans the whole store. The RAM
// itself is not cleared; cells are only read after they were written.
module gap_buffer_text_store #(
	parameter int DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // char_in[7:0], count[18:8], position[28:19], zero
	input  logic [2:0]  s_tuser,   // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // status[1:0], char_out[9:2], text_length[19:10],
	                               // cursor[29:20], zero
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CMPW = (AW + 1 > 11) ? AW + 1 : 11;

	gbts_pkg::state_t  state_q, state_d;
	gbts_pkg::status_t status_q, status_d;
	logic [AW-1:0]     gs_q, gs_d, ge_q, ge_d;
	logic [AW-1:0]     rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
	logic [AW-1:0]     rem_q, rem_d;
	logic              dir_left_q, dir_left_d;
	logic              is_read_q, is_read_d;
	logic              wr_valid_s1, wr_valid_d;
	logic              m_tvalid_q;
	logic [31:0]       m_tdata_q;
	logic              load_out;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [7:0]        ram_wdata, ram_rdata;

	logic              accept;
	gbts_pkg::req_t    req;
	logic [7:0]        char_in;
	logic [CMPW-1:0]   n_ext, pos_ext, gs_ext, room_ext, held_ext, gap_ext, cell_ext;
	logic [AW-1:0]     n_aw;
	logic              full, ok_left, ok_right;
	logic [7:0]        char_out;

	// Unpack the request
	assign req     = gbts_pkg::req_t'(s_tuser);
	assign char_in = s_tdata[7:0];
	assign n_ext   = CMPW'(s_tdata[18:8]);
	assign pos_ext = CMPW'(s_tdata[28:19]);
	assign n_aw    = n_ext[AW-1:0];

	// Gap geometry
	assign gs_ext   = CMPW'(gs_q);
	assign room_ext = CMPW'(AW'(DEPTH - 1) - ge_q);
	assign held_ext = gs_ext + room_ext;
	assign gap_ext  = CMPW'(ge_q) - gs_ext + CMPW'(1);
	assign cell_ext = (pos_ext < gs_ext) ? pos_ext : pos_ext + gap_ext;
	assign full     = (ge_q == gs_q);
	assign ok_left  = (n_ext <= gs_ext);
	assign ok_right = (n_ext <= room_ext);

	assign s_tready = (state_q == gbts_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign char_out = is_read_q ? ram_rdata : 8'd0;

	gbts_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Sequence requests, drive the RAM ports
	always_comb begin
		state_d    = state_q;
		status_d   = status_q;
		gs_d       = gs_q;
		ge_d       = ge_q;
		rd_ptr_d   = rd_ptr_q;
		wr_ptr_d   = wr_ptr_q;
		rem_d      = rem_q;
		dir_left_d = dir_left_q;
		is_read_d  = is_read_q;
		wr_valid_d = 1'b0;
		load_out   = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = gs_q;
		ram_wdata  = char_in;
		ram_re     = 1'b0;
		ram_raddr  = cell_ext[AW-1:0];

		unique case (state_q)
			gbts_pkg::ST_IDLE: begin
				if (accept) begin
					state_d   = gbts_pkg::ST_FINISH;
					status_d  = gbts_pkg::STAT_OK;
					is_read_d = 1'b0;
					case (req)
						gbts_pkg::REQ_INSERT: begin
							if (full) begin
								status_d = gbts_pkg::STAT_FULL;
							end else begin
								ram_we = 1'b1;
								gs_d   = gs_q + AW'(1);
							end
						end
						gbts_pkg::REQ_DEL_LEFT: begin
							if (ok_left) begin
								gs_d = gs_q - n_aw;
							end else begin
								status_d = gbts_pkg::STAT_RANGE;
							end
						end
						gbts_pkg::REQ_DEL_RIGHT: begin
							if (ok_right) begin
								ge_d = ge_q + n_aw;
							end else begin
								status_d = gbts_pkg::STAT_RANGE;
							end
						end
						gbts_pkg::REQ_MOVE_LEFT: begin
							if (ok_left) begin
								gs_d       = gs_q - n_aw;
								ge_d       = ge_q - n_aw;
								rd_ptr_d   = gs_q - AW'(1);
								wr_ptr_d   = ge_q;
								rem_d      = n_aw;
								dir_left_d = 1'b1;
								state_d    = gbts_pkg::ST_COPY;
							end else begin
								status_d = gbts_pkg::STAT_RANGE;
							end
						end
						gbts_pkg::REQ_MOVE_RIGHT: begin
							if (ok_right) begin
								gs_d       = gs_q + n_aw;
								ge_d       = ge_q + n_aw;
								rd_ptr_d   = ge_q + AW'(1);
								wr_ptr_d   = gs_q;
								rem_d      = n_aw;
								dir_left_d = 1'b0;
								state_d    = gbts_pkg::ST_COPY;
							end else begin
								status_d = gbts_pkg::STAT_RANGE;
							end
						end
						gbts_pkg::REQ_READ: begin
							if (pos_ext < held_ext) begin
								ram_re    = 1'b1;
								is_read_d = 1'b1;
							end else begin
								status_d = gbts_pkg::STAT_BEYOND;
							end
						end
						default: begin
							status_d = gbts_pkg::STAT_RANGE;
						end
					endcase
				end
			end
			gbts_pkg::ST_COPY: begin
				// Issue one read per cycle; descending for left moves
				if (rem_q != '0) begin
					ram_re     = 1'b1;
					ram_raddr  = rd_ptr_q;
					rd_ptr_d   = dir_left_q ? rd_ptr_q - AW'(1) : rd_ptr_q + AW'(1);
					rem_d      = rem_q - AW'(1);
					wr_valid_d = 1'b1;
				end else begin
					state_d = gbts_pkg::ST_FINISH;
				end
			end
			gbts_pkg::ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = gbts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gbts_pkg::ST_IDLE;
			end
		endcase

		// Write back the byte read in the previous cycle
		if (wr_valid_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wr_ptr_q;
			ram_wdata = ram_rdata;
			wr_ptr_d  = dir_left_q ? wr_ptr_q - AW'(1) : wr_ptr_q + AW'(1);
		end
	end

	// Control and gap registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gbts_pkg::ST_IDLE;
			gs_q        <= '0;
			ge_q        <= AW'(DEPTH - 1);
			wr_valid_s1 <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			gs_q        <= gs_d;
			ge_q        <= ge_d;
			wr_valid_s1 <= wr_valid_d;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Copy pointers, request flags and result payload
	always_ff @(posedge clk) begin
		status_q   <= status_d;
		rd_ptr_q   <= rd_ptr_d;
		wr_ptr_q   <= wr_ptr_d;
		rem_q      <= rem_d;
		dir_left_q <= dir_left_d;
		is_read_q  <= is_read_d;
		if (load_out) begin
			m_tdata_q <= {2'b00, gs_ext[9:0], held_ext[9:0], char_out, status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// The gap always keeps at least one cell
	a_gap_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ge_q >= gs_q)
		else $error("gap lost its last cell");

	// Copy write never targets the cell being read in the same cycle
	a_copy_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("copy read and write hit the same cell");

	// All copy writes have drained before the result is formed
	a_copy_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gbts_pkg::ST_FINISH) |-> !wr_valid_s1)
		else $error("copy write pending at finish");

	// A new result appears only out of the finish step
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == gbts_pkg::ST_FINISH))
		else $error("result raised outside finish");

endmodule
